// File: rtl/phc_pkg.sv
`default_nettype none
package phc_pkg;

  localparam int unsigned MaxVertices = 32;

  localparam int CoordW   = 32;
  localparam int MulW     = CoordW + 1;
  localparam int ProdW    = 2 * MulW;
  localparam int SideW    = 64;
  localparam int DenW     = SideW + 1;
  localparam int QuoW     = CoordW;
  localparam int NumW     = SideW + QuoW;
  localparam int CntW     = 6;
  localparam int InDataW  = 2 * CoordW;
  localparam int OutDataW = 72;
  localparam int AddrW    = 5;
  localparam int RegW     = 32;

  typedef enum logic [2:0] {
    RegLineX   = 3'd0,
    RegLineY   = 3'd1,
    RegLineDx  = 3'd2,
    RegLineDy  = 3'd3,
    RegKeep    = 3'd4,
    RegSideTol = 3'd5
  } phc_reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StSideM1,
    StSideM2,
    StSideSub,
    StSideAbs,
    StPushA,
    StDen,
    StDif,
    StMulLo,
    StMulHi,
    StNum,
    StDiv,
    StAdd,
    StPushC,
    StEdgeEnd,
    StFlush
  } phc_state_e;

  typedef struct packed {
    logic [CntW-1:0]   cnt;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } phc_rec_t;

endpackage
`default_nettype wire

// File: rtl/phc_mul.sv
`default_nettype none
module phc_mul import phc_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic signed [MulW-1:0]  a_i,
  input  wire logic signed [MulW-1:0]  b_i,
  output logic signed [ProdW-1:0]      p_o
);

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// File: rtl/phc_div.sv
`default_nettype none
module phc_div import phc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NumW-1:0]   num_i,
  input  wire logic [DenW-1:0]   den_i,
  output logic                   done_o,
  output logic [QuoW-1:0]        quo_o
);

  localparam int StepW = $clog2(QuoW);

  logic [DenW-1:0]  rem_q, rem_d;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DenW:0]    trial;
  logic             ge;

  // restoring division; quotient is known to fit QuoW bits
  always_comb begin
    trial  = {rem_q, quo_q[QuoW-1]};
    ge     = trial >= {1'b0, den_i};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = {{(DenW-SideW){1'b0}}, num_i[NumW-1:QuoW]};
      quo_d = num_i[QuoW-1:0];
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? DenW'(trial - {1'b0, den_i}) : trial[DenW-1:0];
      quo_d = {quo_q[QuoW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepW'(QuoW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// File: rtl/polygon_halfplane_clipper_core.sv
`default_nettype none
// Clips one convex polygon against a directed line, one input word per vertex
// (tlast on the closing vertex), and sends the kept vertices and edge crossings
// as output words, the final one with tlast set; a word with tuser low is the
// empty terminator. A sequencer drives one 33x33 multiplier and one radix-2
// divider. Each edge runs its two side tests and the push of the start vertex;
// an edge that crosses the line adds two 32-step divisions (x and y) on the
// shared divider. The closing vertex also runs the closing edge, and tready
// stays low meanwhile, output stalls included. Line registers may be written
// only between words.
module polygon_halfplane_clipper_core import phc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrW-1:0]    paddr,
  input  wire logic [RegW-1:0]     pwdata,
  output logic [RegW-1:0]          prdata,
  output logic                     pready,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // vertex_x, vertex_y
  input  wire logic                s_axis_tlast,  // final_vertex
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,  // clip_x, clip_y, vertex_count
  output logic                     m_axis_tuser,  // vertex_valid
  output logic                     m_axis_tlast   // last
);

  phc_state_e state_q, state_d;

  logic [CoordW-1:0] lx_q, lx_d, ly_q, ly_d, ldx_q, ldx_d, ldy_q, ldy_d;
  logic              kf_q, kf_d;
  logic [RegW-1:0]   tol_q, tol_d;

  logic [CoordW-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic [CoordW-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic              have_first_q, have_first_d;
  logic [CntW-1:0]   count_q, count_d;

  logic [CoordW-1:0] ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic              fin_q, fin_d, closing_q, closing_d, side_sel_q, side_sel_d;
  logic [ProdW-1:0]  acc_q, acc_d, diff_q, diff_d;
  logic              sa_neg_q, sa_neg_d, sb_neg_q, sb_neg_d;
  logic [SideW-1:0]  sa_mag_q, sa_mag_d, sb_mag_q, sb_mag_d;
  logic [DenW-1:0]   den_q, den_d;
  logic              coord_sel_q, coord_sel_d, cneg_q, cneg_d;
  logic [CoordW-1:0] cmag_q, cmag_d, ix_q, ix_d, iy_q, iy_d;

  phc_rec_t          pend_q, pend_d, out_q, out_d, new_rec;
  logic              pend_v_q, pend_v_d, out_v_q, out_v_d;
  logic              out_vv_q, out_vv_d, out_last_q, out_last_d;

  logic signed [MulW-1:0] mul_a, mul_b;
  logic [ProdW-1:0]       prod;
  logic                   div_start, div_done;
  logic [NumW-1:0]        num;
  logic [QuoW-1:0]        quo;

  logic              cfg_wr, out_free, can_push, do_push, below_cap;
  logic              kept_a, crossing, side_neg;
  logic [CoordW-1:0] px, py, ca, cb, coord;
  logic [SideW-1:0]  side_mag;
  logic [MulW-1:0]   cdif;
  logic [ProdW-1:0]  diff_abs;
  phc_reg_e          reg_idx;

  phc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  phc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign reg_idx   = phc_reg_e'(paddr[AddrW-1:2]);
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign pready    = 1'b1;
  assign out_free  = !out_v_q || m_axis_tready;
  assign can_push  = !pend_v_q || out_free;
  assign below_cap = count_q < CntW'(MaxVertices);

  assign px = side_sel_q ? bx_q : ax_q;
  assign py = side_sel_q ? by_q : ay_q;
  assign ca = coord_sel_q ? ay_q : ax_q;
  assign cb = coord_sel_q ? by_q : bx_q;

  assign kept_a   = !sa_neg_q || (sa_mag_q <= SideW'(tol_q));
  assign crossing = (sa_mag_q > SideW'(tol_q)) && (sb_mag_q > SideW'(tol_q)) &&
                    (sa_neg_q != sb_neg_q);

  assign diff_abs = diff_q[ProdW-1] ? ProdW'(-diff_q) : diff_q;
  assign side_mag = diff_abs[SideW-1:0];
  assign side_neg = (side_mag != '0) && (diff_q[ProdW-1] ^ !kf_q);

  assign cdif  = {cb[CoordW-1], cb} - {ca[CoordW-1], ca};
  assign num   = {prod[SideW-1:0], {QuoW{1'b0}}} + {{QuoW{1'b0}}, acc_q[SideW-1:0]};
  assign coord = cneg_q ? ca - quo : ca + quo;

  always_comb begin
    case (reg_idx)
      RegLineX:   prdata = lx_q;
      RegLineY:   prdata = ly_q;
      RegLineDx:  prdata = ldx_q;
      RegLineDy:  prdata = ldy_q;
      RegKeep:    prdata = {{(RegW-1){1'b0}}, kf_q};
      RegSideTol: prdata = tol_q;
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    case (state_q)
      StSideM1: begin
        mul_a = {ldy_q[CoordW-1], ldy_q};
        mul_b = {px[CoordW-1], px} - {lx_q[CoordW-1], lx_q};
      end
      StSideM2: begin
        mul_a = {ldx_q[CoordW-1], ldx_q};
        mul_b = {py[CoordW-1], py} - {ly_q[CoordW-1], ly_q};
      end
      StMulLo: begin
        mul_a = {1'b0, sa_mag_q[CoordW-1:0]};
        mul_b = {1'b0, cmag_q};
      end
      StMulHi: begin
        mul_a = {1'b0, sa_mag_q[SideW-1:CoordW]};
        mul_b = {1'b0, cmag_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    lx_d         = lx_q;
    ly_d         = ly_q;
    ldx_d        = ldx_q;
    ldy_d        = ldy_q;
    kf_d         = kf_q;
    tol_d        = tol_q;
    first_x_d    = first_x_q;
    first_y_d    = first_y_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    have_first_d = have_first_q;
    count_d      = count_q;
    ax_d         = ax_q;
    ay_d         = ay_q;
    bx_d         = bx_q;
    by_d         = by_q;
    fin_d        = fin_q;
    closing_d    = closing_q;
    side_sel_d   = side_sel_q;
    acc_d        = acc_q;
    diff_d       = diff_q;
    sa_neg_d     = sa_neg_q;
    sa_mag_d     = sa_mag_q;
    sb_neg_d     = sb_neg_q;
    sb_mag_d     = sb_mag_q;
    den_d        = den_q;
    coord_sel_d  = coord_sel_q;
    cneg_d       = cneg_q;
    cmag_d       = cmag_q;
    ix_d         = ix_q;
    iy_d         = iy_q;
    pend_d       = pend_q;
    pend_v_d     = pend_v_q;
    out_d        = out_q;
    out_v_d      = out_v_q && !m_axis_tready;
    out_vv_d     = out_vv_q;
    out_last_d   = out_last_q;
    s_axis_tready = 1'b0;
    div_start    = 1'b0;
    do_push      = 1'b0;
    new_rec      = '{cnt: count_q + 1'b1, x: ax_q, y: ay_q};

    if (cfg_wr) begin
      case (reg_idx)
        RegLineX:   lx_d  = pwdata;
        RegLineY:   ly_d  = pwdata;
        RegLineDx:  ldx_d = pwdata;
        RegLineDy:  ldy_d = pwdata;
        RegKeep:    kf_d  = pwdata[0];
        RegSideTol: tol_d = pwdata;
        default:    ;
      endcase
    end

    case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          side_sel_d = 1'b0;
          fin_d      = s_axis_tlast;
          prev_x_d   = s_axis_tdata[CoordW-1:0];
          prev_y_d   = s_axis_tdata[InDataW-1:CoordW];
          bx_d       = s_axis_tdata[CoordW-1:0];
          by_d       = s_axis_tdata[InDataW-1:CoordW];
          if (!have_first_q) begin
            first_x_d    = s_axis_tdata[CoordW-1:0];
            first_y_d    = s_axis_tdata[InDataW-1:CoordW];
            have_first_d = 1'b1;
            ax_d         = s_axis_tdata[CoordW-1:0];
            ay_d         = s_axis_tdata[InDataW-1:CoordW];
            closing_d    = 1'b1;
            if (s_axis_tlast) begin
              state_d = StSideM1;
            end
          end else begin
            ax_d      = prev_x_q;
            ay_d      = prev_y_q;
            closing_d = 1'b0;
            state_d   = StSideM1;
          end
        end
      end
      StSideM1: begin
        state_d = StSideM2;
      end
      StSideM2: begin
        acc_d   = prod;
        state_d = StSideSub;
      end
      StSideSub: begin
        diff_d  = acc_q - prod;
        state_d = StSideAbs;
      end
      StSideAbs: begin
        if (!side_sel_q) begin
          sa_mag_d   = side_mag;
          sa_neg_d   = side_neg;
          side_sel_d = 1'b1;
          state_d    = StSideM1;
        end else begin
          sb_mag_d = side_mag;
          sb_neg_d = side_neg;
          state_d  = StPushA;
        end
      end
      StPushA: begin
        if (!(kept_a && below_cap && !can_push)) begin
          do_push = kept_a && below_cap;
          state_d = crossing ? StDen : StEdgeEnd;
        end
      end
      StDen: begin
        den_d       = {1'b0, sa_mag_q} + {1'b0, sb_mag_q};
        coord_sel_d = 1'b0;
        state_d     = StDif;
      end
      StDif: begin
        cneg_d  = cdif[MulW-1];
        cmag_d  = cdif[MulW-1] ? CoordW'(-cdif) : cdif[CoordW-1:0];
        state_d = StMulLo;
      end
      StMulLo: begin
        state_d = StMulHi;
      end
      StMulHi: begin
        acc_d   = prod;
        state_d = StNum;
      end
      StNum: begin
        div_start = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        if (!coord_sel_q) begin
          ix_d        = coord;
          coord_sel_d = 1'b1;
          state_d     = StDif;
        end else begin
          iy_d    = coord;
          state_d = StPushC;
        end
      end
      StPushC: begin
        new_rec.x = ix_q;
        new_rec.y = iy_q;
        if (!(below_cap && !can_push)) begin
          do_push = below_cap;
          state_d = StEdgeEnd;
        end
      end
      StEdgeEnd: begin
        if (!closing_q && fin_q) begin
          ax_d       = bx_q;
          ay_d       = by_q;
          bx_d       = first_x_q;
          by_d       = first_y_q;
          closing_d  = 1'b1;
          side_sel_d = 1'b0;
          state_d    = StSideM1;
        end else begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (fin_q) begin
          if (out_free) begin
            out_v_d      = 1'b1;
            out_last_d   = 1'b1;
            out_vv_d     = pend_v_q;
            out_d        = pend_v_q ? pend_q : '{cnt: count_q, x: '0, y: '0};
            pend_v_d     = 1'b0;
            count_d      = '0;
            have_first_d = 1'b0;
            state_d      = StIdle;
          end
        end else if (!pend_v_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_last_d = 1'b0;
          out_vv_d   = 1'b1;
          out_d      = pend_q;
          pend_v_d   = 1'b0;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // a held word moves out once a newer one shows it was not the last; StFlush also sends it
    if (do_push) begin
      count_d  = count_q + 1'b1;
      pend_d   = new_rec;
      pend_v_d = 1'b1;
      if (pend_v_q) begin
        out_d      = pend_q;
        out_v_d    = 1'b1;
        out_vv_d   = 1'b1;
        out_last_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      lx_q         <= '0;
      ly_q         <= '0;
      ldx_q        <= CoordW'(65536);
      ldy_q        <= '0;
      kf_q         <= 1'b1;
      tol_q        <= RegW'(4295);
      first_x_q    <= '0;
      first_y_q    <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      have_first_q <= 1'b0;
      count_q      <= '0;
      fin_q        <= 1'b0;
      closing_q    <= 1'b0;
      side_sel_q   <= 1'b0;
      coord_sel_q  <= 1'b0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      lx_q         <= lx_d;
      ly_q         <= ly_d;
      ldx_q        <= ldx_d;
      ldy_q        <= ldy_d;
      kf_q         <= kf_d;
      tol_q        <= tol_d;
      first_x_q    <= first_x_d;
      first_y_q    <= first_y_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      have_first_q <= have_first_d;
      count_q      <= count_d;
      fin_q        <= fin_d;
      closing_q    <= closing_d;
      side_sel_q   <= side_sel_d;
      coord_sel_q  <= coord_sel_d;
      pend_v_q     <= pend_v_d;
      out_v_q      <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q       <= ax_d;
    ay_q       <= ay_d;
    bx_q       <= bx_d;
    by_q       <= by_d;
    acc_q      <= acc_d;
    diff_q     <= diff_d;
    sa_neg_q   <= sa_neg_d;
    sa_mag_q   <= sa_mag_d;
    sb_neg_q   <= sb_neg_d;
    sb_mag_q   <= sb_mag_d;
    den_q      <= den_d;
    cneg_q     <= cneg_d;
    cmag_q     <= cmag_d;
    ix_q       <= ix_d;
    iy_q       <= iy_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_vv_q   <= out_vv_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OutDataW-CntW-InDataW){1'b0}}, out_q};
  assign m_axis_tuser  = out_vv_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// File: rtl/phc_checker.sv
`default_nettype none
module phc_checker import phc_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                s_axis_tlast,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,  // clip_x, clip_y, vertex_count
  input wire logic                m_axis_tuser,  // vertex_valid
  input wire logic                m_axis_tlast   // last
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_term_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast &&
      m_axis_tdata[InDataW-1:0] == '0)
    else $error("terminator word malformed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[InDataW+CntW-1:InDataW] != '0 &&
      m_axis_tdata[InDataW+CntW-1:InDataW] <= CntW'(MaxVertices))
    else $error("vertex count out of range");

  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("closing vertex did not start the closing edge");

endmodule

bind polygon_halfplane_clipper_core phc_checker u_phc_checker (.*);
`default_nettype wire
